// File: hdl/assert_macros.svh
// assertion macros for the rtl files, included by rpb_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked on every rising clock edge outside reset
`define ASSERT_CHK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// condition that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CHK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

// File: hdl/rpb_pkg.sv
// types, constants and helpers of the ready priority bitmap unit
package rpb_pkg;

  // priority space and counter size
  localparam int NUM_PRIORITIES = 512;
  localparam int COUNT_WIDTH    = 8;
  localparam int CNT_AW         = $clog2(NUM_PRIORITIES);

  // bitmap geometry: three levels of eight bits
  localparam int PRIO_W = 9;
  localparam int IDX_W  = 3;
  localparam int ROW_W  = 6;
  localparam int LEVEL_W = 8;
  localparam int NUM_ROWS = 64;
  localparam int NUM_GROUPS = 8;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [1:0]             cmd_t;
  typedef logic [1:0]             op_t;
  typedef logic [1:0]             status_t;
  typedef logic [PRIO_W-1:0]      prio_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [ROW_W-1:0]       row_t;
  typedef logic [LEVEL_W-1:0]     level_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;

  localparam count_t COUNT_MAX = '1;

  // command codes on the request channel
  localparam cmd_t CMD_ADD    = 2'd0;
  localparam cmd_t CMD_REMOVE = 2'd1;
  localparam cmd_t CMD_QUERY  = 2'd2;

  // classified operations
  localparam op_t OP_ADD    = 2'd0;
  localparam op_t OP_REMOVE = 2'd1;
  localparam op_t OP_QUERY  = 2'd2;

  // result status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_SAT   = 2'd2;

  // classified work item handed from front to back
  typedef struct packed {
    op_t   op;
    idx_t  grp;
    idx_t  mid;
    idx_t  low;
    prio_t cur;
  } work_item_t;

  // index of the lowest set bit, zero when none is set
  function automatic idx_t lsb8(input level_t v);
    idx_t r;
    r = '0;
    for (int i = LEVEL_W - 1; i >= 0; i--) begin
      if (v[i]) r = idx_t'(i);
    end
    return r;
  endfunction

endpackage

// File: hdl/rpb_if.sv
// request and response channel interfaces
interface rpb_req_if;
  logic            valid;
  logic            ready;
  rpb_pkg::cmd_t   cmd;
  rpb_pkg::prio_t  task_priority;
  rpb_pkg::prio_t  current_priority;

  modport source (output valid, output cmd, output task_priority,
                  output current_priority, input ready);
  modport sink (input valid, input cmd, input task_priority,
                input current_priority, output ready);
endinterface

interface rpb_rsp_if;
  logic              valid;
  logic              ready;
  rpb_pkg::prio_t    best_priority;
  logic              any_ready;
  logic              preempt;
  rpb_pkg::status_t  status;

  modport source (output valid, output best_priority, output any_ready,
                  output preempt, output status, input ready);
  modport sink (input valid, input best_priority, input any_ready,
                input preempt, input status, output ready);
endinterface

// File: hdl/rpb_front.sv
// front end: accepts requests and classifies them into work items
module rpb_front (
  rpb_req_if.sink              req,
  output logic                 item_valid,
  input  logic                 item_ready,
  output rpb_pkg::work_item_t  item
);
  import rpb_pkg::*;

  logic in_range;

  // priorities beyond the configured space are ignored
  assign in_range = ({1'b0, req.task_priority} < (PRIO_W + 1)'(NUM_PRIORITIES));

  // command decode, unused code and out of range fall back to query
  always_comb begin
    item.grp = req.task_priority[2*IDX_W +: IDX_W];
    item.mid = req.task_priority[IDX_W +: IDX_W];
    item.low = req.task_priority[0 +: IDX_W];
    item.cur = req.current_priority;
    unique case (req.cmd)
      CMD_ADD:    item.op = in_range ? OP_ADD : OP_QUERY;
      CMD_REMOVE: item.op = in_range ? OP_REMOVE : OP_QUERY;
      default:    item.op = OP_QUERY;
    endcase
  end

  // handshake passes straight to the queue
  assign item_valid = req.valid;
  assign req.ready  = item_ready;

endmodule

// File: hdl/rpb_queue.sv
// short queue of work items between front and back
module rpb_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rpb_pkg::work_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rpb_pkg::work_item_t  out_item
);
  import rpb_pkg::*;

  work_item_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                push;
  logic                pop;

  assign in_ready  = (count != QCNT_W'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= in_item;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// File: hdl/rpb_back.sv
// back end: count and bitmap update, three level lookup, result register
`include "assert_macros.svh"

module rpb_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  rpb_pkg::work_item_t  item,
  rpb_rsp_if.source            rsp
);
  import rpb_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_LK1  = 3'd2;
  localparam logic [2:0] S_LK2  = 3'd3;
  localparam logic [2:0] S_LK3  = 3'd4;

  logic [2:0]  state;
  work_item_t  item_q;
  status_t     status_q;
  idx_t        g_q;
  idx_t        m_q;

  // memories and their valid bits
  count_t                count_mem [NUM_PRIORITIES];
  level_t                bot_mem   [NUM_ROWS];
  level_t                mid_mem   [NUM_GROUPS];
  logic [NUM_ROWS-1:0]   bot_valid;
  logic [NUM_GROUPS-1:0] mid_valid;
  level_t                top;

  count_t  cnt_rd;
  level_t  bot_rd;
  level_t  mid_rd;
  logic    bot_rd_v;
  logic    mid_rd_v;
  level_t  bot_eff;
  level_t  mid_eff;
  count_t  cnt_eff;

  logic [CNT_AW-1:0] cnt_raddr;
  logic [CNT_AW-1:0] cnt_waddr;
  row_t    bot_raddr;
  row_t    item_row;
  idx_t    mid_raddr;
  logic    bot_re;
  logic    mid_re;
  prio_t   head_prio;
  prio_t   item_prio;

  // update datapath
  logic    cnt_we;
  count_t  cnt_wdata;
  logic    bot_we;
  level_t  bot_wdata;
  logic    mid_we;
  level_t  mid_wdata;
  level_t  top_next;
  status_t upd_status;
  level_t  bit_g;
  level_t  bit_m;
  level_t  bit_l;

  // result
  logic    rsp_valid_q;
  prio_t   best_q;
  logic    any_q;
  logic    preempt_q;
  status_t rsp_status_q;
  logic    load;
  logic    any_c;
  prio_t   best_c;

  assign head_prio = {item.grp, item.mid, item.low};
  assign item_prio = {item_q.grp, item_q.mid, item_q.low};
  assign item_row  = {item_q.grp, item_q.mid};
  assign cnt_raddr = head_prio[CNT_AW-1:0];
  assign cnt_waddr = item_prio[CNT_AW-1:0];

  assign item_ready = (state == S_IDLE);

  // read addresses follow the step in progress
  assign bot_re    = (state == S_IDLE) || (state == S_LK2);
  assign mid_re    = (state == S_IDLE) || (state == S_LK1);
  assign bot_raddr = (state == S_LK2) ? {g_q, lsb8(mid_eff)} : {item.grp, item.mid};
  assign mid_raddr = (state == S_LK1) ? lsb8(top) : item.grp;

  // entries never written read as empty
  assign bot_eff = bot_rd_v ? bot_rd : '0;
  assign mid_eff = mid_rd_v ? mid_rd : '0;
  assign cnt_eff = bot_eff[item_q.low] ? cnt_rd : '0;

  assign bit_g = level_t'(1) << item_q.grp;
  assign bit_m = level_t'(1) << item_q.mid;
  assign bit_l = level_t'(1) << item_q.low;

  // read-modify-write of count and the three levels
  always_comb begin
    cnt_we     = 1'b0;
    cnt_wdata  = cnt_eff;
    bot_we     = 1'b0;
    bot_wdata  = bot_eff;
    mid_we     = 1'b0;
    mid_wdata  = mid_eff;
    top_next   = top;
    upd_status = ST_OK;
    if (item_q.op == OP_ADD) begin
      if (cnt_eff == COUNT_MAX) begin
        upd_status = ST_SAT;
      end else begin
        cnt_we    = 1'b1;
        cnt_wdata = cnt_eff + 1'b1;
        bot_we    = 1'b1;
        bot_wdata = bot_eff | bit_l;
        mid_we    = 1'b1;
        mid_wdata = mid_eff | bit_m;
        top_next  = top | bit_g;
      end
    end else if (item_q.op == OP_REMOVE) begin
      if (cnt_eff == '0) begin
        upd_status = ST_EMPTY;
      end else begin
        cnt_we    = 1'b1;
        cnt_wdata = cnt_eff - 1'b1;
        if (cnt_eff == COUNT_WIDTH'(1)) begin
          bot_we    = 1'b1;
          bot_wdata = bot_eff & ~bit_l;
          if (bot_wdata == '0) begin
            mid_we    = 1'b1;
            mid_wdata = mid_eff & ~bit_m;
            if (mid_wdata == '0) top_next = top & ~bit_g;
          end
        end
      end
    end
  end

  // count memory
  always_ff @(posedge clk) begin
    if (state == S_IDLE) cnt_rd <= count_mem[cnt_raddr];
    if (state == S_UPD && cnt_we) count_mem[cnt_waddr] <= cnt_wdata;
  end

  // bottom level memory
  always_ff @(posedge clk) begin
    if (bot_re) begin
      bot_rd   <= bot_mem[bot_raddr];
      bot_rd_v <= bot_valid[bot_raddr];
    end
    if (state == S_UPD && bot_we) bot_mem[item_row] <= bot_wdata;
  end

  // middle level memory
  always_ff @(posedge clk) begin
    if (mid_re) begin
      mid_rd   <= mid_mem[mid_raddr];
      mid_rd_v <= mid_valid[mid_raddr];
    end
    if (state == S_UPD && mid_we) mid_mem[item_q.grp] <= mid_wdata;
  end

  // valid bits and top level
  always_ff @(posedge clk) begin
    if (rst) begin
      bot_valid <= '0;
      mid_valid <= '0;
      top       <= '0;
    end else if (state == S_UPD) begin
      if (bot_we) bot_valid[item_row] <= 1'b1;
      if (mid_we) mid_valid[item_q.grp] <= 1'b1;
      top <= top_next;
    end
  end

  // result of the lookup walk
  assign any_c  = (top != '0);
  assign best_c = any_c ? {g_q, m_q, lsb8(bot_eff)} : '0;
  assign load   = (state == S_LK3) && (!rsp_valid_q || rsp.ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) state <= (item.op == OP_QUERY) ? S_LK1 : S_UPD;
        end
        S_UPD: state <= S_LK1;
        S_LK1: state <= S_LK2;
        S_LK2: state <= S_LK3;
        S_LK3: begin
          if (load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // item and lookup registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) begin
      item_q   <= item;
      status_q <= ST_OK;
    end
    if (state == S_UPD) status_q <= upd_status;
    if (state == S_LK1) g_q <= lsb8(top);
    if (state == S_LK2) m_q <= lsb8(mid_eff);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid_q <= 1'b0;
    end else if (load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      best_q       <= best_c;
      any_q        <= any_c;
      preempt_q    <= any_c && (best_c < item_q.cur);
      rsp_status_q <= status_q;
    end
  end

  assign rsp.valid         = rsp_valid_q;
  assign rsp.best_priority = best_q;
  assign rsp.any_ready     = any_q;
  assign rsp.preempt       = preempt_q;
  assign rsp.status        = rsp_status_q;

  // checks
  `ASSERT_CHK(a_top_has_mid, clk, rst, ((top & ~mid_valid) == '0))
  `ASSERT_CHK(a_upd_from_idle, clk, rst, (state == S_UPD) |-> ($past(state) == S_IDLE))
  `ASSERT_CHK(a_query_ok, clk, rst, (state == S_LK1 && item_q.op == OP_QUERY) |-> (status_q == ST_OK))
  `ASSERT_NEVER(a_preempt_needs_ready, clk, rst, rsp_valid_q && preempt_q && !any_q)

endmodule

// File: hdl/ready_priority_bitmap_unit.sv
// top level of the ready priority bitmap unit
//
//   channel  dir  modport  payload
//   req      in   sink     cmd, task_priority, current_priority
//   rsp      out  source   best_priority, any_ready, preempt, status
//
// add and remove run the count read-modify-write, through the registered count
// memory read, and then the walk over the three bitmap levels, one memory read
// per level; query runs only the walk.
// reset is synchronous; no clearing pass, bitmap rows carry valid bits and
// the count of a priority is taken as zero while its bottom bit is clear.
// a two entry queue lets requests be taken while the back end works, and the
// output register lets the next item run up to its last lookup step while a result waits.
module ready_priority_bitmap_unit (
  input  logic       clk,
  input  logic       rst,
  rpb_req_if.sink    req,
  rpb_rsp_if.source  rsp
);
  import rpb_pkg::*;

  logic        f_valid;
  logic        f_ready;
  work_item_t  f_item;
  logic        q_valid;
  logic        q_ready;
  work_item_t  q_item;

  // classify incoming requests
  rpb_front u_front (
    .req        (req),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  // decoupling queue
  rpb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  // update and lookup engine
  rpb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .rsp        (rsp)
  );

endmodule
